[sv/ekmr_sparse_index_encoder_unit_assert.svh]
// Assertion macros shared by the encoder's RTL files.
`ifndef EKMR_SPARSE_INDEX_ENCODER_UNIT_ASSERT_SVH
`define EKMR_SPARSE_INDEX_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EKMR_SIE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ekmr_sie assertion failed");
`define EKMR_SIE_NEVER(lbl, clk, rst_n, cond) \
  `EKMR_SIE_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define EKMR_SIE_ASSERT(lbl, clk, rst_n, prop)
`define EKMR_SIE_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[sv/ekmr_sie_pkg.sv]
// Types and constants of the EKMR sparse index encoder.
package ekmr_sie_pkg;

  localparam int CoordW   = 16;
  localparam int ValueW   = 64;
  localparam int PosW     = 21;
  localparam int IndexW   = 32;
  localparam int CfgDataW = 16;
  localparam int CfgIdxW  = 1;

  localparam longint unsigned MAX_NONZEROS_DEF = 64'd1048576;
  localparam int              COORD_BITS_DEF   = 16;

  localparam int QUEUE_DEPTH = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ORIENTATION = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MERGE       = 1'd1;

  typedef enum logic {
    KIND_POINTER = 1'b0,
    KIND_ELEMENT = 1'b1
  } entry_kind_t;

  typedef struct packed {
    logic [CoordW-1:0] coord_i;
    logic [CoordW-1:0] coord_j;
    logic [CoordW-1:0] coord_k;
    logic [ValueW-1:0] element_value;
    logic              last_tuple;
  } in_item_t;

  typedef struct packed {
    entry_kind_t       entry_kind;
    logic [PosW-1:0]   pointer_value;
    logic [IndexW-1:0] packed_index;
    logic [ValueW-1:0] value_out;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic              orientation_mode;
    logic [CoordW-1:0] merge_factor;
  } cfg_t;

  // one classified tuple: which results it produces and their payloads
  typedef struct packed {
    logic              start_ptr;
    logic              key_ptr;
    logic [PosW-1:0]   key_pos;
    logic [IndexW-1:0] elem_idx;
    logic [ValueW-1:0] elem_val;
    logic              last;
    logic [PosW-1:0]   last_pos;
  } plan_t;

endpackage

[sv/ekmr_sie_front.sv]
// Front end: accepts tuples, forms the merged index and classifies segment changes.
module ekmr_sie_front #(
  parameter longint unsigned MAX_NONZEROS = ekmr_sie_pkg::MAX_NONZEROS_DEF,
  parameter int              COORD_BITS   = ekmr_sie_pkg::COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ekmr_sie_pkg::cfg_t     cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ekmr_sie_pkg::in_item_t in_data,
  output logic                   q_push,
  input  logic                   q_ready,
  output ekmr_sie_pkg::plan_t    q_data
);
  import ekmr_sie_pkg::*;

  localparam logic [CoordW-1:0] COORD_MASK = (COORD_BITS >= CoordW) ? {CoordW{1'b1}} :
                                             CoordW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [PosW-1:0]   POS_LIMIT  = (MAX_NONZEROS > ((64'd1 << PosW) - 64'd1)) ?
                                             {PosW{1'b1}} : PosW'(MAX_NONZEROS);

  // stage A: masked coordinates and registered merged index
  logic              a_valid_r, a_valid_nxt;
  logic [CoordW-1:0] a_ci_r, a_ci_nxt;
  logic [IndexW-1:0] a_merged_r, a_merged_nxt;
  logic [ValueW-1:0] a_val_r, a_val_nxt;
  logic              a_last_r, a_last_nxt;

  // segment state
  logic [IndexW-1:0] prev_key_r, prev_key_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic              at_start_r, at_start_nxt;

  logic [CoordW-1:0] mj, mk;
  logic [IndexW-1:0] key, elem_idx;
  logic              key_chg;
  logic [PosW-1:0]   pos_inc;
  logic              take;

  assign in_ready = !a_valid_r || q_ready;
  assign take     = a_valid_r && q_ready;
  assign q_push   = a_valid_r;

  always_comb begin
    mj           = in_data.coord_j & COORD_MASK;
    mk           = in_data.coord_k & COORD_MASK;
    a_valid_nxt  = a_valid_r;
    a_ci_nxt     = a_ci_r;
    a_merged_nxt = a_merged_r;
    a_val_nxt    = a_val_r;
    a_last_nxt   = a_last_r;
    if (in_ready) begin
      a_valid_nxt = in_valid;
    end
    if (in_valid && in_ready) begin
      a_ci_nxt     = in_data.coord_i & COORD_MASK;
      a_merged_nxt = IndexW'(mj) * IndexW'(cfg.merge_factor) + IndexW'(mk);
      a_val_nxt    = in_data.element_value;
      a_last_nxt   = in_data.last_tuple;
    end
  end

  always_comb begin
    if (cfg.orientation_mode) begin
      key      = a_merged_r;
      elem_idx = IndexW'(a_ci_r);
    end else begin
      key      = IndexW'(a_ci_r);
      elem_idx = a_merged_r;
    end
    key_chg = (key != prev_key_r);
    pos_inc = (pos_r < POS_LIMIT) ? pos_r + PosW'(1) : pos_r;

    q_data.start_ptr = at_start_r;
    q_data.key_ptr   = key_chg;
    q_data.key_pos   = pos_r;
    q_data.elem_idx  = elem_idx;
    q_data.elem_val  = a_val_r;
    q_data.last      = a_last_r;
    q_data.last_pos  = pos_inc;

    prev_key_nxt = prev_key_r;
    pos_nxt      = pos_r;
    at_start_nxt = at_start_r;
    if (take) begin
      if (a_last_r) begin
        // tensor done: back to the reset state
        prev_key_nxt = '0;
        pos_nxt      = '0;
        at_start_nxt = 1'b1;
      end else begin
        prev_key_nxt = key;
        pos_nxt      = pos_inc;
        at_start_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r  <= 1'b0;
      prev_key_r <= '0;
      pos_r      <= '0;
      at_start_r <= 1'b1;
    end else begin
      a_valid_r  <= a_valid_nxt;
      prev_key_r <= prev_key_nxt;
      pos_r      <= pos_nxt;
      at_start_r <= at_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_ci_r     <= a_ci_nxt;
    a_merged_r <= a_merged_nxt;
    a_val_r    <= a_val_nxt;
    a_last_r   <= a_last_nxt;
  end

endmodule

[sv/ekmr_sie_queue.sv]
// Small register queue of classified tuples between front and back end.
`include "ekmr_sparse_index_encoder_unit_assert.svh"
module ekmr_sie_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                push_ready,
  input  ekmr_sie_pkg::plan_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output ekmr_sie_pkg::plan_t pop_data
);
  import ekmr_sie_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(QUEUE_DEPTH);

  plan_t           slot_r [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != FullCnt);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastSlot) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastSlot) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `EKMR_SIE_NEVER(a_count_bound, clk, rst_n, count_r > FullCnt)
  `EKMR_SIE_ASSERT(a_ptr_gap, clk, rst_n, (count_r == '0 || count_r == FullCnt) |-> (wr_ptr_r == rd_ptr_r))
  `EKMR_SIE_ASSERT(a_count_step, clk, rst_n, (do_push && !do_pop) |=> (count_r == $past(count_r) + CntW'(1)))

endmodule

[sv/ekmr_sie_back.sv]
// Back end: expands one classified tuple into its pointer and element transactions.
`include "ekmr_sparse_index_encoder_unit_assert.svh"
module ekmr_sie_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  ekmr_sie_pkg::plan_t     q_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ekmr_sie_pkg::out_item_t out_data
);
  import ekmr_sie_pkg::*;

  // pending mask: bit 0 start pointer, 1 key pointer, 2 element, 3 final count
  logic        w_valid_r, w_valid_nxt;
  logic [3:0]  w_pend_r, w_pend_nxt;
  plan_t       w_plan_r, w_plan_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        emit_ok, load;
  logic [3:0]  pick, rem;
  out_item_t   sel;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign emit_ok   = w_valid_r && (!out_valid_r || out_ready);

  always_comb begin
    sel = '{entry_kind: KIND_POINTER, pointer_value: '0, packed_index: '0,
            value_out: '0, last_result: 1'b0};
    if (w_pend_r[0]) begin
      pick = 4'b0001;
    end else if (w_pend_r[1]) begin
      pick              = 4'b0010;
      sel.pointer_value = w_plan_r.key_pos;
    end else if (w_pend_r[2]) begin
      pick             = 4'b0100;
      sel.entry_kind   = KIND_ELEMENT;
      sel.packed_index = w_plan_r.elem_idx;
      sel.value_out    = w_plan_r.elem_val;
    end else begin
      pick              = 4'b1000;
      sel.pointer_value = w_plan_r.last_pos;
      sel.last_result   = 1'b1;
    end
    rem   = w_pend_r & ~pick;
    load  = !w_valid_r || (emit_ok && rem == '0);
    q_pop = load && q_valid;

    w_valid_nxt = w_valid_r;
    w_pend_nxt  = w_pend_r;
    w_plan_nxt  = w_plan_r;
    if (load) begin
      w_valid_nxt = q_valid;
      w_plan_nxt  = q_data;
      w_pend_nxt  = {q_data.last, 1'b1, q_data.key_ptr, q_data.start_ptr};
    end else if (emit_ok) begin
      w_pend_nxt = rem;
    end

    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (!out_valid_r || out_ready) begin
      out_valid_nxt = emit_ok;
      out_data_nxt  = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      w_pend_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      w_valid_r   <= w_valid_nxt;
      w_pend_r    <= w_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_plan_r   <= w_plan_nxt;
    out_data_r <= out_data_nxt;
  end

  `EKMR_SIE_ASSERT(a_work_pending, clk, rst_n, w_valid_r |-> (w_pend_r != '0))
  `EKMR_SIE_ASSERT(a_hold_when_blocked, clk, rst_n, (w_valid_r && !emit_ok) |=> $stable(w_pend_r))
  `EKMR_SIE_ASSERT(a_last_is_pointer, clk, rst_n, (out_valid_r && out_data_r.last_result) |-> (out_data_r.entry_kind == KIND_POINTER))

endmodule

[sv/ekmr_sparse_index_encoder_unit.sv]
// Top level of the EKMR sparse index encoder: config registers, front, queue, back.
//
// Usage:
//   in_*  : valid/ready channel of sorted tuples (i,j,k,value,last_tuple).
//   out_* : valid/ready channel of entries: pointer entries (segment start or
//           final total count, flagged by last_result) and element entries.
//   cfg_* : write-only port; index 0 orientation (0 row, 1 column),
//           index 1 merge factor r. Write only while the block is idle.
// Each tuple yields one element transaction, plus a pointer transaction when
// its segment key changes, plus pointer 0 on the first tuple of a tensor and
// the total count after the last one: 1 to 4 output transactions.
// Throughput: the back end emits one transaction per cycle while the receiver
// is ready, one per result of a tuple (typically 1-2, at most 4); the front end
// takes a tuple every cycle while the 4-entry queue has room.
// On an empty pipe a tuple's first result passes the merge register, queue,
// work register and output register, in that order.
// Reset (synchronous, rst_n low) clears queue, pipelines, config registers
// and the segment state; no clearing pass.
// When the receiver stalls, out_data holds, the queue fills and in_ready
// drops only once the queue and the front register are full.
module ekmr_sparse_index_encoder_unit #(
  parameter longint unsigned MAX_NONZEROS = ekmr_sie_pkg::MAX_NONZEROS_DEF,
  parameter int              COORD_BITS   = ekmr_sie_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ekmr_sie_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ekmr_sie_pkg::out_item_t              out_data,
  input  logic                                 cfg_we,
  input  logic [ekmr_sie_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ekmr_sie_pkg::CfgDataW-1:0]    cfg_wdata
);
  import ekmr_sie_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_push_ready, q_valid, q_pop;
  plan_t q_in, q_out;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIENTATION: cfg_nxt.orientation_mode = cfg_wdata[0];
        CFG_MERGE:       cfg_nxt.merge_factor     = cfg_wdata[CoordW-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ekmr_sie_front #(
    .MAX_NONZEROS(MAX_NONZEROS),
    .COORD_BITS  (COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_push  (q_push),
    .q_ready (q_push_ready),
    .q_data  (q_in)
  );

  ekmr_sie_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_ready(q_push_ready),
    .push_data (q_in),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_data  (q_out)
  );

  ekmr_sie_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_data   (q_out),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[dv/ekmr_sparse_index_encoder_unit_checker.sv]
// Checker: predicts the encoder's entries from observed transactions and compares them.
`timescale 1ns / 100ps

module ekmr_sparse_index_encoder_unit_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  ekmr_sie_pkg::in_item_t              in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  ekmr_sie_pkg::out_item_t             out_data,
  input  logic                                cfg_we,
  input  logic [ekmr_sie_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ekmr_sie_pkg::CfgDataW-1:0]   cfg_wdata,
  output int                                  err_count,
  output int                                  pending
);
  import ekmr_sie_pkg::*;

  localparam longint unsigned PosMax   = (64'd1 << PosW) - 64'd1;
  localparam longint unsigned PosLimit =
    (MAX_NONZEROS_DEF < PosMax) ? MAX_NONZEROS_DEF : PosMax;

  // register copies
  logic              col_mode   = 1'b0;
  logic [CoordW-1:0] merge_r    = '0;

  // segment state
  logic [IndexW-1:0] prev_key   = '0;
  logic [PosW-1:0]   nz_count   = '0;
  logic              tensor_new = 1'b1;

  out_item_t expected_entries[$];
  int        fail_total = 0;
  int        shown      = 0;
  int        pend_count = 0;

  assign err_count = fail_total;
  assign pending   = pend_count;

  function automatic out_item_t pointer_entry(logic [PosW-1:0] pos, logic fin);
    out_item_t e;
    e               = '0;
    e.entry_kind    = KIND_POINTER;
    e.pointer_value = pos;
    e.last_result   = fin;
    return e;
  endfunction

  task automatic encode_tuple(in_item_t t);
    logic [IndexW-1:0] merged;
    logic [IndexW-1:0] key;
    logic [IndexW-1:0] idx;
    out_item_t         elem;
    // coordinates are already COORD_BITS wide, so no masking is needed
    merged = IndexW'(64'(t.coord_j) * 64'(merge_r) + 64'(t.coord_k));
    if (!col_mode) begin
      key = IndexW'(t.coord_i);
      idx = merged;
    end else begin
      key = merged;
      idx = IndexW'(t.coord_i);
    end
    if (tensor_new) begin
      expected_entries.push_back(pointer_entry('0, 1'b0));
      tensor_new = 1'b0;
    end
    if (key != prev_key) begin
      expected_entries.push_back(pointer_entry(nz_count, 1'b0));
      prev_key = key;
    end
    elem              = '0;
    elem.entry_kind   = KIND_ELEMENT;
    elem.packed_index = idx;
    elem.value_out    = t.element_value;
    expected_entries.push_back(elem);
    if (64'(nz_count) < PosLimit) nz_count = nz_count + PosW'(1);
    if (t.last_tuple) begin
      expected_entries.push_back(pointer_entry(nz_count, 1'b1));
      prev_key   = '0;
      nz_count   = '0;
      tensor_new = 1'b1;
    end
  endtask

  task automatic check_entry(out_item_t got);
    out_item_t want;
    if (expected_entries.size() == 0) begin
      fail_total++;
      if (shown < 10) begin
        shown++;
        $display("%0t: unexpected entry kind %0d ptr %h idx %h val %h last %b", $realtime,
                 got.entry_kind, got.pointer_value, got.packed_index, got.value_out,
                 got.last_result);
      end
    end else begin
      want = expected_entries.pop_front();
      if (got.entry_kind !== want.entry_kind || got.pointer_value !== want.pointer_value ||
          got.packed_index !== want.packed_index || got.value_out !== want.value_out ||
          got.last_result !== want.last_result) begin
        fail_total++;
        if (shown < 10) begin
          shown++;
          $display("%0t: mismatch exp kind %0d ptr %h idx %h val %h last %b", $realtime,
                   want.entry_kind, want.pointer_value, want.packed_index, want.value_out,
                   want.last_result);
          $display("            got kind %0d ptr %h idx %h val %h last %b",
                   got.entry_kind, got.pointer_value, got.packed_index, got.value_out,
                   got.last_result);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      col_mode   = 1'b0;
      merge_r    = '0;
      prev_key   = '0;
      nz_count   = '0;
      tensor_new = 1'b1;
      expected_entries.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIENTATION: col_mode = cfg_wdata[0];
          CFG_MERGE:       merge_r  = cfg_wdata[CoordW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_tuple(in_data);
      if (out_valid && out_ready) check_entry(out_data);
    end
    pend_count = expected_entries.size();
  end

endmodule

[dv/ekmr_sparse_index_encoder_unit_tb.sv]
// Testbench top: stimulus, receiver back-pressure, watchdog and verdict for the encoder.
`timescale 1ns / 100ps

module ekmr_sparse_index_encoder_unit_tb;
  import ekmr_sie_pkg::*;

  localparam bit ModeRow = 1'b0;
  localparam bit ModeCol = 1'b1;
  // cycles without any transaction before the run is declared hung; the worst
  // legitimate quiet stretch is a long sender gap or a long receiver stall
  localparam int WatchdogLimit = 2000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int err_count;
  int pending;
  int sent_count  = 0;
  int idle_cycles = 0;
  int ready_hold  = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  ekmr_sparse_index_encoder_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ekmr_sparse_index_encoder_unit_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .err_count (err_count),
    .pending   (pending)
  );

  // Receiver: alternate ready bursts with short and occasional long stalls.
  // At most one assignment to out_ready per falling edge.
  always @(negedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (pick < 50) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(1, 20);
    end else if (pick < 85) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(8, 30);
    end
  end

  // Watchdog: any transaction on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back-to-back or short gaps, a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return CoordW'($urandom);
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance.
  // A gap drops valid first; with no gap valid simply stays high.
  task automatic push_tuple(input logic [CoordW-1:0] ci, input logic [CoordW-1:0] cj,
                            input logic [CoordW-1:0] ck, input logic [ValueW-1:0] v,
                            input logic lt, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid              <= 1'b1;
    in_data.coord_i       <= ci;
    in_data.coord_j       <= cj;
    in_data.coord_k       <= ck;
    in_data.element_value <= v;
    in_data.last_tuple    <= lt;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // Sender holds off until every expected entry has been seen.
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Registers change only with the block drained; an extra wait covers
  // the pipe latency.
  task automatic set_mode(input logic mode, input logic [CoordW-1:0] r);
    hold_until_empty();
    repeat (6) @(negedge clk);
    write_reg(CFG_ORIENTATION, CfgDataW'(mode));
    write_reg(CFG_MERGE, CfgDataW'(r));
  endtask

  // Well-formed tensor: segments of equal key with increasing keys. Now and
  // then the closing last_tuple is dropped so the next tensor continues it.
  task automatic send_tensor(input logic mode);
    int nseg;
    int nper;
    bit drop_last;
    bit gaps_on;
    logic lt;
    logic [CoordW-1:0] key_i;
    logic [CoordW-1:0] key_j;
    logic [CoordW-1:0] key_k;
    nseg      = $urandom_range(1, 4);
    drop_last = ($urandom_range(0, 9) == 0);
    gaps_on   = ($urandom_range(0, 3) != 0);
    key_i     = ($urandom_range(0, 2) == 0) ? '0 : CoordW'($urandom_range(0, 60000));
    key_j     = ($urandom_range(0, 2) == 0) ? '0 : CoordW'($urandom_range(0, 60000));
    key_k     = rand_coord();
    for (int s = 0; s < nseg; s++) begin
      nper = $urandom_range(1, 4);
      for (int t = 0; t < nper; t++) begin
        lt = !drop_last && (s == nseg - 1) && (t == nper - 1);
        if (mode == ModeCol)
          push_tuple(rand_coord(), key_j, key_k, rand_value(), lt, gaps_on ? pick_gap() : 0);
        else
          push_tuple(key_i, rand_coord(), rand_coord(), rand_value(), lt,
                     gaps_on ? pick_gap() : 0);
      end
      key_i = key_i + CoordW'($urandom_range(1, 300));
      key_j = key_j + CoordW'($urandom_range(1, 300));
    end
  endtask

  task automatic random_phase(input logic mode, input logic [CoordW-1:0] r, input int n);
    int start;
    set_mode(mode, r);
    start = sent_count;
    while (sent_count - start < n) begin
      if ($urandom_range(0, 3) == 0)
        push_tuple(rand_coord(), rand_coord(), rand_coord(), rand_value(),
                   ($urandom_range(0, 2) == 0), pick_gap());
      else
        send_tensor(mode);
      if ($urandom_range(0, 6) == 0) hold_until_empty();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed: row orientation, r = 15 ---
    write_reg(CFG_ORIENTATION, CfgDataW'(ModeRow));
    write_reg(CFG_MERGE, CfgDataW'(15));
    push_tuple(16'd0, 16'd0, 16'd0, '0, 1'b0, 0);          // start pointer, key 0 kept
    push_tuple(16'd0, 16'd1, 16'd2, '1, 1'b0, 0);
    push_tuple(16'd1, 16'd0, 16'd5, 64'h0123_4567_89ab_cdef, 1'b0, 1);
    push_tuple(16'd1, 16'hffff, 16'hffff, 64'h8000_0000_0000_0001, 1'b0, 0);
    push_tuple(16'd3, 16'd2, 16'd1, 64'h5555_aaaa_5555_aaaa, 1'b1, 0);  // total count
    // single-tuple tensor whose first key is not zero: pointer 0 twice
    push_tuple(16'd7, 16'd0, 16'd0, 64'haaaa_5555_aaaa_5555, 1'b1, 0);
    push_tuple(16'hffff, 16'hffff, 16'hffff, '1, 1'b0, 2);
    push_tuple(16'hffff, 16'd0, 16'd0, '0, 1'b1, 0);

    // --- directed: row, widest merge factor ---
    set_mode(ModeRow, 16'hffff);
    push_tuple(16'd2, 16'hffff, 16'hffff, '1, 1'b0, 0);
    push_tuple(16'd2, 16'd0, 16'hffff, 64'd1, 1'b0, 0);
    push_tuple(16'd5, 16'd1, 16'd0, 64'd2, 1'b1, 0);

    // --- directed: column orientation, widest merge factor ---
    set_mode(ModeCol, 16'hffff);
    push_tuple(16'd4, 16'd0, 16'd0, '0, 1'b0, 0);
    push_tuple(16'd9, 16'd0, 16'hffff, '1, 1'b0, 0);
    push_tuple(16'hffff, 16'hffff, 16'hffff, 64'hdead_beef_0000_ffff, 1'b0, 0);
    push_tuple(16'd0, 16'hffff, 16'hffff, 64'h1, 1'b1, 0);

    // --- directed: column, r = 0 so key is k alone ---
    set_mode(ModeCol, 16'd0);
    push_tuple(16'd1, 16'd5, 16'd0, 64'd3, 1'b0, 0);
    push_tuple(16'd2, 16'd9, 16'd0, 64'd4, 1'b0, 0);       // j differs, same key
    push_tuple(16'd3, 16'd0, 16'd4, 64'd5, 1'b0, 0);
    push_tuple(16'hffff, 16'hffff, 16'hffff, '1, 1'b1, 0);
    push_tuple(16'd0, 16'd0, 16'd8, '0, 1'b1, 3);          // first key not zero

    // --- random phases over several register settings ---
    random_phase(ModeRow, CoordW'($urandom), 35);
    random_phase(ModeCol, CoordW'($urandom), 35);
    random_phase(ModeRow, 16'd0, 35);
    random_phase(ModeCol, 16'hffff, 35);
    random_phase(ModeRow, 16'hffff, 35);
    random_phase(ModeCol, 16'd1, 35);

    hold_until_empty();
    repeat (8) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/ekmr_sie_pkg.sv
sv/ekmr_sie_front.sv
sv/ekmr_sie_queue.sv
sv/ekmr_sie_back.sv
sv/ekmr_sparse_index_encoder_unit.sv
dv/ekmr_sparse_index_encoder_unit_checker.sv
dv/ekmr_sparse_index_encoder_unit_tb.sv
